>>> rtl/auto_gain_exposure_control_macros.svh
// Assertion macros for the auto gain and exposure controller.
`ifndef AUTO_GAIN_EXPOSURE_CONTROL_MACROS_SVH
`define AUTO_GAIN_EXPOSURE_CONTROL_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define AGEC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// A condition that must follow from another at the same or the next edge.
`define AGEC_ASSERT_IMPL(label, seq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) seq) \
		else $error("assertion failed");

`endif

>>> rtl/agec_pkg.sv
// Package with types and constants of the auto gain and exposure controller.
package agec_pkg;

	localparam int SUM_W = 28;
	localparam int CNT_W = 21;
	localparam logic [CNT_W-1:0] MAX_SAMPLES = CNT_W'(1048576);
	localparam int DIV_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int VAL_W = 36;
	localparam int LIM_W = 20;
	localparam int STEPS_W = 7;
	localparam int MULT_W = 9;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_EXPOSURE_MIN     = 3'd0,
		REG_EXPOSURE_MAX     = 3'd1,
		REG_EXPOSURE_DEFAULT = 3'd2,
		REG_EXPOSURE_STEP    = 3'd3,
		REG_GAIN_MIN         = 3'd4,
		REG_GAIN_MAX         = 3'd5,
		REG_GAIN_DEFAULT     = 3'd6,
		REG_GAIN_STEP        = 3'd7
	} agec_reg_t;

	typedef struct packed {
		logic [15:0] emin;
		logic [15:0] emax;
		logic [15:0] edef;
		logic [15:0] estp;
		logic [15:0] gmin;
		logic [15:0] gmax;
		logic [15:0] gdef;
		logic [15:0] gstp;
	} agec_cfg_t;

	// One finished frame as handed from the front to the back.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic             enable;
		logic [7:0]       target;
		logic [15:0]      gain;
		logic [15:0]      expo;
	} agec_frame_t;

	typedef struct packed {
		logic [7:0]  average_luma;
		logic        settle_soon;
		logic        exposure_changed;
		logic        gain_changed;
		logic [15:0] new_exposure;
		logic [15:0] new_gain;
	} agec_result_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_AVG,
		B_TEN,
		B_SDIV,
		B_STEP,
		B_SELECT,
		B_RANGE,
		B_MUL1,
		B_MUL2,
		B_CLAMP,
		B_EMIT
	} agec_state_t;

	// Saturate a signed value to the 16-bit unsigned range.
	function automatic logic [15:0] sat16(input logic signed [VAL_W-1:0] v);
		logic [15:0] r;
		if (v < 0)
			r = 16'd0;
		else if (v > VAL_W'(65535))
			r = 16'hFFFF;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

>>> rtl/agec_div.sv
// Bit-serial signed divider that truncates toward zero.
module agec_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [agec_pkg::DIV_W-1:0] dividend,
	input  logic signed [agec_pkg::DIV_W-1:0] divisor,
	output logic                              done,
	output logic signed [agec_pkg::DIV_W-1:0] quotient
);
	import agec_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic                 done_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_W:0]       rem_q;
	logic [DIV_W:0]       rem_sh;
	logic                 fits;

	// One quotient bit per cycle from the shifted remainder.
	always_comb begin
		rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
		fits = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIV_W-1] ^ divisor[DIV_W-1];
			quo_q <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
			den_q <= divisor[DIV_W-1] ? DIV_W'(-divisor) : DIV_W'(divisor);
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> rtl/agec_fifo.sv
// Two-entry frame queue between the accumulating front and the control back.
module agec_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  agec_pkg::agec_frame_t wr_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output agec_pkg::agec_frame_t rd_data
);
	import agec_pkg::*;

	agec_frame_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	assign full = fill_q == 2'd2;
	assign empty = fill_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

endmodule

>>> rtl/agec_front.sv
// Front end: sums window samples and queues a frame record at end of frame.
module agec_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [7:0]            sample,
	input  logic                  enable,
	input  logic [7:0]            target,
	input  logic [15:0]           gain_now,
	input  logic [15:0]           exposure_now,
	output logic                  push,
	output agec_pkg::agec_frame_t frame,
	input  logic                  full
);
	import agec_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;

	assign in_ready = !full;
	assign accept = in_valid && !full;
	assign push = accept && kind;

	always_comb begin
		frame.sum = sum_q;
		frame.count = count_q;
		frame.enable = enable;
		frame.target = target;
		frame.gain = gain_now;
		frame.expo = exposure_now;
	end

	// Accumulate until the sample limit; any end of frame clears the sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (kind) begin
				sum_q <= '0;
				count_q <= '0;
			end else if (count_q < MAX_SAMPLES) begin
				sum_q <= sum_q + SUM_W'(sample);
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/agec_back.sv
// Back end: mean, step count and knee-chain correction for one frame at a time.
module agec_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  agec_pkg::agec_cfg_t    cfg,
	input  logic                   empty,
	input  agec_pkg::agec_frame_t  frame,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output agec_pkg::agec_result_t out_data
);
	import agec_pkg::*;

	agec_state_t state_q, state_d;
	agec_frame_t frame_q;
	agec_result_t out_q;
	logic out_valid_q;
	logic issued_q;
	logic [7:0] avg_q;
	logic signed [DIV_W-1:0] t_q;
	logic signed [LIM_W-1:0] elow_q;
	logic signed [STEPS_W-1:0] steps_q;
	logic signed [STEPS_W-1:0] last_q;
	logic sel_expo_q;
	logic accel_q;
	logic signed [LIM_W-1:0] limit_q;
	logic signed [MULT_W-1:0] mult_q;
	logic signed [24:0] p1_q;
	logic signed [33:0] p2_q;
	logic signed [VAL_W-1:0] gain_v_q;
	logic signed [VAL_W-1:0] expo_v_q;

	logic div_start, div_done, div_wait;
	logic signed [DIV_W-1:0] div_a, div_b, quo;
	logic [15:0] estp, gstp, stp, lo, hi;
	logic signed [LIM_W-1:0] expo_s, gain_s, edef_s, gdef_s, emin_s, emax_s, gmin_s, gmax_s;
	logic signed [STEPS_W-1:0] raw_steps, new_steps;
	logic signed [DIV_W-1:0] s_cl;
	logic signed [34:0] s_prod;
	logic [STEPS_W-1:0] mag;
	logic signed [16:0] ten_diff;
	logic [15:0] ten_mag;
	logic [31:0] ten_prod;
	logic signed [DIV_W-1:0] ten_quo;
	logic signed [8:0] step_diff;
	logic [7:0] step_mag;
	logic [17:0] step_prod;
	logic signed [VAL_W-1:0] cur, moved, clamped;
	logic found, f_expo, f_accel;
	logic signed [LIM_W-1:0] f_limit;
	logic emit_ok;

	agec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quo)
	);

	// Step registers of zero act as one; values widened for signed compares.
	always_comb begin
		estp = (cfg.estp == '0) ? 16'd1 : cfg.estp;
		gstp = (cfg.gstp == '0) ? 16'd1 : cfg.gstp;
		stp = sel_expo_q ? estp : gstp;
		lo = sel_expo_q ? cfg.emin : cfg.gmin;
		hi = sel_expo_q ? cfg.emax : cfg.gmax;
		expo_s = LIM_W'(expo_v_q);
		gain_s = LIM_W'(gain_v_q);
		edef_s = $signed({4'b0, cfg.edef});
		gdef_s = $signed({4'b0, cfg.gdef});
		emin_s = $signed({4'b0, cfg.emin});
		emax_s = $signed({4'b0, cfg.emax});
		gmin_s = $signed({4'b0, cfg.gmin});
		gmax_s = $signed({4'b0, cfg.gmax});
		emit_ok = !out_valid_q || out_ready;
	end

	// Derived values. Division by ten and by six uses reciprocal multiplication
	// on the magnitude, which is exact over these operand ranges.
	always_comb begin
		ten_diff = $signed({1'b0, cfg.emax}) - $signed({1'b0, cfg.emin});
		ten_mag = ten_diff[16] ? 16'(-ten_diff) : ten_diff[15:0];
		ten_prod = 32'(ten_mag) * 32'd52429;
		ten_quo = ten_diff[16] ? -$signed(DIV_W'(ten_prod[31:19])) :
			$signed(DIV_W'(ten_prod[31:19]));
		step_diff = $signed({1'b0, frame_q.target}) - $signed({1'b0, avg_q});
		step_mag = step_diff[8] ? 8'(-step_diff) : step_diff[7:0];
		step_prod = 18'(step_mag) * 18'd171;
		raw_steps = step_diff[8] ? -$signed(STEPS_W'(step_prod[17:10])) :
			$signed(STEPS_W'(step_prod[17:10]));
		if ((raw_steps > 0 && last_q < 0) || (raw_steps < 0 && last_q > 0))
			new_steps = (raw_steps + $signed(STEPS_W'(raw_steps < 0))) >>> 1;
		else
			new_steps = raw_steps;
		s_cl = (quo > DIV_W'(10)) ? DIV_W'(10) : quo;
		s_prod = $signed(s_cl[16:0]) * $signed({1'b0, estp});
		mag = steps_q < 0 ? STEPS_W'(-steps_q) : steps_q;
	end

	// Knee priority chain: only the first stage with room moves.
	always_comb begin
		found = 1'b1;
		f_expo = 1'b1;
		f_accel = 1'b1;
		f_limit = edef_s;
		if (steps_q < 0) begin
			if (expo_s > edef_s) begin
				f_limit = edef_s;
			end else if (gain_s > gdef_s) begin
				f_expo = 1'b0;
				f_limit = gdef_s;
			end else if (expo_s > elow_q) begin
				f_limit = elow_q;
			end else if (gain_s > gmin_s) begin
				f_expo = 1'b0;
				f_limit = gmin_s;
			end else if (expo_s > emin_s) begin
				f_limit = emin_s;
				f_accel = 1'b0;
			end else begin
				found = 1'b0;
			end
		end else if (steps_q > 0) begin
			if (expo_s < elow_q) begin
				f_limit = elow_q;
				f_accel = 1'b0;
			end else if (gain_s < gdef_s) begin
				f_expo = 1'b0;
				f_limit = gdef_s;
			end else if (expo_s < edef_s) begin
				f_limit = edef_s;
			end else if (gain_s < gmax_s) begin
				f_expo = 1'b0;
				f_limit = gmax_s;
			end else if (expo_s < emax_s) begin
				f_limit = emax_s;
			end else begin
				found = 1'b0;
			end
		end else begin
			found = 1'b0;
		end
	end

	// Move and clamp at the stage limit.
	always_comb begin
		cur = sel_expo_q ? expo_v_q : gain_v_q;
		moved = cur + VAL_W'(p2_q);
		clamped = moved;
		if (steps_q > 0) begin
			if (moved > VAL_W'(limit_q))
				clamped = VAL_W'(limit_q);
		end else if (moved < VAL_W'(limit_q)) begin
			clamped = VAL_W'(limit_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!empty) state_d = frame.enable ? B_AVG : B_IDLE;
			B_AVG: if (frame_q.count == '0 || div_done) state_d = B_TEN;
			B_TEN: state_d = B_SDIV;
			B_SDIV: if (div_done) state_d = B_STEP;
			B_STEP: state_d = B_SELECT;
			B_SELECT: state_d = found ? B_RANGE : B_EMIT;
			B_RANGE: if (div_done) state_d = B_MUL1;
			B_MUL1: state_d = B_MUL2;
			B_MUL2: state_d = B_CLAMP;
			B_CLAMP: state_d = B_EMIT;
			B_EMIT: if (emit_ok) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Outputs of the sequencer: queue pop and divider operands.
	always_comb begin
		pop = 1'b0;
		div_wait = 1'b0;
		div_a = '0;
		div_b = DIV_W'(1);
		unique case (state_q)
			B_IDLE: pop = !empty;
			B_AVG: begin
				div_wait = frame_q.count != '0;
				div_a = DIV_W'(frame_q.sum);
				div_b = DIV_W'(frame_q.count);
			end
			B_SDIV: begin
				div_wait = 1'b1;
				div_a = t_q;
				div_b = DIV_W'(estp);
			end
			B_RANGE: begin
				div_wait = 1'b1;
				div_a = DIV_W'($signed({1'b0, hi}) - $signed({1'b0, lo}));
				div_b = DIV_W'(stp);
			end
			default: div_wait = 1'b0;
		endcase
		div_start = div_wait && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			issued_q <= 1'b0;
			last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_start)
				issued_q <= 1'b1;
			else if (div_done)
				issued_q <= 1'b0;
			if (state_q == B_IDLE && !empty && !frame.enable)
				last_q <= '0;
			if (state_q == B_CLAMP)
				last_q <= steps_q;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == B_EMIT && emit_ok)
				out_valid_q <= 1'b1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: frame_q <= frame;
			B_AVG: avg_q <= (frame_q.count == '0) ? 8'd0 : quo[7:0];
			B_TEN: t_q <= ten_quo;
			B_SDIV: elow_q <= LIM_W'(s_prod + 35'(cfg.emin));
			B_STEP: begin
				steps_q <= new_steps;
				gain_v_q <= VAL_W'(frame_q.gain);
				expo_v_q <= VAL_W'(frame_q.expo);
			end
			B_SELECT: begin
				sel_expo_q <= f_expo;
				accel_q <= f_accel;
				limit_q <= f_limit;
				if (!found)
					steps_q <= '0;
			end
			B_RANGE: begin
				if (accel_q && mag >= STEPS_W'(3) && quo > DIV_W'(256))
					mult_q <= $signed({1'b0, quo[15:8]});
				else if (accel_q && quo > DIV_W'(1024))
					mult_q <= $signed({3'b0, quo[15:10]});
				else
					mult_q <= MULT_W'(1);
			end
			B_MUL1: p1_q <= steps_q * $signed({2'b0, stp});
			B_MUL2: p2_q <= p1_q * mult_q;
			B_CLAMP: begin
				if (sel_expo_q)
					expo_v_q <= clamped;
				else
					gain_v_q <= clamped;
			end
			B_EMIT: begin
				if (emit_ok) begin
					out_q.new_gain <= sat16(gain_v_q);
					out_q.new_exposure <= sat16(expo_v_q);
					out_q.gain_changed <= sat16(gain_v_q) != frame_q.gain;
					out_q.exposure_changed <= sat16(expo_v_q) != frame_q.expo;
					out_q.settle_soon <= steps_q != '0;
					out_q.average_luma <= avg_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

>>> rtl/auto_gain_exposure_control.sv
// Top level of the auto gain and exposure controller.
// Words are taken one per cycle; all input stalls while the two-frame queue is full.
// An end-of-frame word's result needs up to three passes through the 32-bit serial
// divider (for the mean, the low exposure knee and the step range); the back end
// takes a new frame only once it has emitted the result of the last one.
// Reset (arst_n low) clears accumulators, correction history and queue, and sets config to defaults.
module auto_gain_exposure_control (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sample[7:0], enable[8], target[16:9], gain_now[32:17], exposure_now[48:33]
	input  logic [55:0] s_axis_tdata,
	// kind[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// new_gain[15:0], new_exposure[31:16], gain_changed[32], exposure_changed[33],
	// settle_soon[34], average_luma[42:35]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import agec_pkg::*;

	agec_cfg_t    cfg_q;
	agec_frame_t  push_frame, pop_frame;
	agec_result_t result;
	logic         push, full, pop, empty;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.emin <= 16'd0;
			cfg_q.emax <= 16'hFFFF;
			cfg_q.edef <= 16'h8000;
			cfg_q.estp <= 16'd1;
			cfg_q.gmin <= 16'd0;
			cfg_q.gmax <= 16'hFFFF;
			cfg_q.gdef <= 16'h8000;
			cfg_q.gstp <= 16'd1;
		end else if (cfg_valid) begin
			unique case (agec_reg_t'(cfg_index))
				REG_EXPOSURE_MIN: cfg_q.emin <= cfg_data;
				REG_EXPOSURE_MAX: cfg_q.emax <= cfg_data;
				REG_EXPOSURE_DEFAULT: cfg_q.edef <= cfg_data;
				REG_EXPOSURE_STEP: cfg_q.estp <= cfg_data;
				REG_GAIN_MIN: cfg_q.gmin <= cfg_data;
				REG_GAIN_MAX: cfg_q.gmax <= cfg_data;
				REG_GAIN_DEFAULT: cfg_q.gdef <= cfg_data;
				REG_GAIN_STEP: cfg_q.gstp <= cfg_data;
				default: ;
			endcase
		end
	end

	agec_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.kind         (s_axis_tuser),
		.sample       (s_axis_tdata[7:0]),
		.enable       (s_axis_tdata[8]),
		.target       (s_axis_tdata[16:9]),
		.gain_now     (s_axis_tdata[32:17]),
		.exposure_now (s_axis_tdata[48:33]),
		.push         (push),
		.frame        (push_frame),
		.full         (full)
	);

	agec_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_frame),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.rd_data (pop_frame)
	);

	agec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.frame     (pop_frame),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result)
	);

	assign m_axis_tdata = {5'b0, result};

endmodule

>>> rtl/agec_checker.sv
// Port-level checker for the auto gain and exposure controller, with its bind.
`include "auto_gain_exposure_control_macros.svh"

module agec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        cfg_ready
);

	// A stalled result word stays put.
	`AGEC_ASSERT_IMPL(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)))
	// Without a correction neither setting is reported as changed.
	`AGEC_ASSERT_IMPL(a_no_change, (m_axis_tvalid && !m_axis_tdata[34] |-> !m_axis_tdata[32] && !m_axis_tdata[33]))
	// Padding bits of the result word are zero.
	`AGEC_ASSERT_ALWAYS(a_pad_zero, (!m_axis_tvalid || m_axis_tdata[47:43] == 5'd0))
	// Configuration writes are always taken.
	`AGEC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)

endmodule

bind auto_gain_exposure_control agec_checker u_agec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);

>>> tb/sv/agec_scoreboard.sv
`timescale 1ns / 1ps
// Checker that predicts the controller's results from the observed words and compares them.
module agec_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	import agec_pkg::*;

	localparam longint SAMPLE_LIMIT = 1048576;

	// Shadow of the block's registers and frame state.
	logic [15:0]    regs [8];
	longint         luma_acc;
	longint         luma_cnt;
	longint         prev_corr;
	agec_result_t   frame_results [$];

	// Move one control toward a stage limit, with coarse steps for fine controls.
	function automatic longint step_toward(longint v, longint lo, longint hi, longint stp,
			longint n, longint lim, bit accel);
		longint rng;
		longint mag;
		longint mult;
		rng = (hi - lo) / stp;
		mag = (n < 0) ? -n : n;
		mult = 1;
		if (accel && mag >= 3 && rng > 256)
			mult = rng / 256;
		else if (accel && rng > 1024)
			mult = rng / 1024;
		v += n * stp * mult;
		if (n > 0) begin
			if (v > lim) v = lim;
		end else begin
			if (v < lim) v = lim;
		end
		return v;
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v < 0) return 16'd0;
		if (v > 65535) return 16'hFFFF;
		return v[15:0];
	endfunction

	// Work out the correction at an enabled end of frame.
	function automatic agec_result_t predict_frame_end(longint avg, longint target,
			longint gain0, longint expo0);
		agec_result_t r;
		longint emin, emax, edef, estp, gmin, gmax, gdef, gstp;
		longint s, elow, n, gain, expo;
		emin = regs[REG_EXPOSURE_MIN];
		emax = regs[REG_EXPOSURE_MAX];
		edef = regs[REG_EXPOSURE_DEFAULT];
		estp = (regs[REG_EXPOSURE_STEP] == 0) ? 1 : regs[REG_EXPOSURE_STEP];
		gmin = regs[REG_GAIN_MIN];
		gmax = regs[REG_GAIN_MAX];
		gdef = regs[REG_GAIN_DEFAULT];
		gstp = (regs[REG_GAIN_STEP] == 0) ? 1 : regs[REG_GAIN_STEP];
		gain = gain0;
		expo = expo0;
		s = ((emax - emin) / 10) / estp;
		if (s > 10) s = 10;
		elow = s * estp + emin;
		n = (target - avg) / 6;
		if ((n > 0 && prev_corr < 0) || (n < 0 && prev_corr > 0))
			n = n / 2;
		if (n < 0) begin
			if (expo > edef)
				expo = step_toward(expo, emin, emax, estp, n, edef, 1);
			else if (gain > gdef)
				gain = step_toward(gain, gmin, gmax, gstp, n, gdef, 1);
			else if (expo > elow)
				expo = step_toward(expo, emin, emax, estp, n, elow, 1);
			else if (gain > gmin)
				gain = step_toward(gain, gmin, gmax, gstp, n, gmin, 1);
			else if (expo > emin)
				expo = step_toward(expo, emin, emax, estp, n, emin, 0);
			else
				n = 0;
		end else if (n > 0) begin
			if (expo < elow)
				expo = step_toward(expo, emin, emax, estp, n, elow, 0);
			else if (gain < gdef)
				gain = step_toward(gain, gmin, gmax, gstp, n, gdef, 1);
			else if (expo < edef)
				expo = step_toward(expo, emin, emax, estp, n, edef, 1);
			else if (gain < gmax)
				gain = step_toward(gain, gmin, gmax, gstp, n, gmax, 1);
			else if (expo < emax)
				expo = step_toward(expo, emin, emax, estp, n, emax, 1);
			else
				n = 0;
		end
		if (n != 0)
			prev_corr = n;
		r.new_gain = clip16(gain);
		r.new_exposure = clip16(expo);
		r.gain_changed = (r.new_gain != gain0[15:0]);
		r.exposure_changed = (r.new_exposure != expo0[15:0]);
		r.settle_soon = (n != 0);
		r.average_luma = avg[7:0];
		return r;
	endfunction

	assign pending = frame_results.size();

	// Follow every accepted word on the three channels.
	always @(posedge clk or negedge arst_n) begin
		longint avg;
		agec_result_t got;
		agec_result_t want;
		if (!arst_n) begin
			regs[REG_EXPOSURE_MIN] = 16'd0;
			regs[REG_EXPOSURE_MAX] = 16'hFFFF;
			regs[REG_EXPOSURE_DEFAULT] = 16'h8000;
			regs[REG_EXPOSURE_STEP] = 16'd1;
			regs[REG_GAIN_MIN] = 16'd0;
			regs[REG_GAIN_MAX] = 16'hFFFF;
			regs[REG_GAIN_DEFAULT] = 16'h8000;
			regs[REG_GAIN_STEP] = 16'd1;
			luma_acc = 0;
			luma_cnt = 0;
			prev_corr = 0;
			errors = 0;
			frame_results.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				regs[cfg_index] = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (!s_axis_tuser) begin
					if (luma_cnt < SAMPLE_LIMIT) begin
						luma_acc += s_axis_tdata[7:0];
						luma_cnt++;
					end
				end else begin
					avg = (luma_cnt != 0) ? luma_acc / luma_cnt : 0;
					luma_acc = 0;
					luma_cnt = 0;
					if (!s_axis_tdata[8])
						prev_corr = 0;
					else
						frame_results.push_back(predict_frame_end(avg, s_axis_tdata[16:9],
							s_axis_tdata[32:17], s_axis_tdata[48:33]));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[42:0];
				if (frame_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word %h", got);
				end else begin
					want = frame_results.pop_front();
					if (got.new_gain !== want.new_gain ||
							got.new_exposure !== want.new_exposure ||
							got.gain_changed !== want.gain_changed ||
							got.exposure_changed !== want.exposure_changed ||
							got.settle_soon !== want.settle_soon ||
							got.average_luma !== want.average_luma) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected gain %0d expo %0d gc %0b ec %0b ss %0b avg %0d, got gain %0d expo %0d gc %0b ec %0b ss %0b avg %0d",
								want.new_gain, want.new_exposure, want.gain_changed,
								want.exposure_changed, want.settle_soon, want.average_luma,
								got.new_gain, got.new_exposure, got.gain_changed,
								got.exposure_changed, got.settle_soon, got.average_luma);
					end
				end
			end
		end
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the controller testbench: clock, reset, stimulus and verdict.
module tb_top;
	import agec_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          errors;
	int          pending;

	bit          quiet = 0;
	bit          long_hold = 0;
	int          idle_cycles = 0;
	logic [15:0] cur_regs [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	auto_gain_exposure_control i_dut (.*);

	agec_scoreboard i_scoreboard (.*);

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("auto_gain_exposure_control regression: fail");
			$finish;
		end
	end

	// Result side: random stall bursts, one long hold-off on request.
	initial begin
		int n;
		bit hold_done;
		hold_done = 0;
		forever begin
			if (long_hold && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (800) @(posedge clk);
				hold_done = 1;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				n = $urandom_range(1, 19);
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(1, 19);
				repeat (n) @(posedge clk);
			end
		end
	end

	// Offer one word and hold it until the block takes it, then maybe pause.
	task automatic send_word(bit kind, logic [7:0] smp, bit en, logic [7:0] tgt,
			logic [15:0] gain, logic [15:0] expo, bit may_gap);
		bit rdy;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {7'd0, expo, gain, tgt, en, smp};
		forever begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
			if (rdy) break;
		end
		if (may_gap && !quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(agec_reg_t idx, logic [15:0] val);
		bit rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
			if (rdy) break;
		end
		cfg_valid <= 1'b0;
		cur_regs[idx] = val;
	endtask

	// Wait until every expected result has come, then let queued frames finish.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic load_regs(logic [15:0] emin, logic [15:0] emax, logic [15:0] edef,
			logic [15:0] estp, logic [15:0] gmin, logic [15:0] gmax, logic [15:0] gdef,
			logic [15:0] gstp);
		write_reg(REG_EXPOSURE_MIN, emin);
		write_reg(REG_EXPOSURE_MAX, emax);
		write_reg(REG_EXPOSURE_DEFAULT, edef);
		write_reg(REG_EXPOSURE_STEP, estp);
		write_reg(REG_GAIN_MIN, gmin);
		write_reg(REG_GAIN_MAX, gmax);
		write_reg(REG_GAIN_DEFAULT, gdef);
		write_reg(REG_GAIN_STEP, gstp);
	endtask

	// A gain or exposure value near an interesting point of the current settings.
	function automatic logic [15:0] pick_setting(bit is_gain);
		logic [15:0] base;
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: base = is_gain ? cur_regs[REG_GAIN_MIN] : cur_regs[REG_EXPOSURE_MIN];
			1: base = is_gain ? cur_regs[REG_GAIN_MAX] : cur_regs[REG_EXPOSURE_MAX];
			2, 3: base = is_gain ? cur_regs[REG_GAIN_DEFAULT] : cur_regs[REG_EXPOSURE_DEFAULT];
			4: base = 16'd0;
			5: base = 16'hFFFF;
			default: base = 16'($urandom_range(0, 65535));
		endcase
		if ($urandom_range(0, 1))
			base = base + 16'($urandom_range(0, 40)) - 16'd20;
		return base;
	endfunction

	// One frame: a run of window samples and an end word; returns the word count.
	task automatic send_frame(int nsamp, logic [7:0] lo, logic [7:0] hi, bit en,
			logic [7:0] tgt, logic [15:0] gain, logic [15:0] expo, output int words);
		for (int i = 0; i < nsamp; i++)
			send_word(1'b0, 8'($urandom_range(lo, hi)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 1'b1);
		send_word(1'b1, 8'($urandom_range(0, 255)), en, tgt, gain, expo, 1'b1);
		words = nsamp + 1;
	endtask

	task automatic random_frames(int budget);
		int sent;
		int w;
		int lo;
		int hi;
		sent = 0;
		while (sent < budget) begin
			lo = $urandom_range(0, 255);
			hi = $urandom_range(lo, 255);
			send_frame($urandom_range(0, 12), 8'(lo), 8'(hi), $urandom_range(0, 9) != 0,
				8'($urandom_range(0, 255)), pick_setting(1), pick_setting(0), w);
			sent += w;
		end
	endtask

	initial begin
		int w;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, then the directed frames.
		load_regs(16'd0, 16'hFFFF, 16'h8000, 16'd1, 16'd0, 16'hFFFF, 16'h8000, 16'd1);
		send_frame(0, 0, 0, 1, 8'd255, 16'd0, 16'd0, w);          // no samples, brighten
		send_frame(3, 255, 255, 1, 8'd0, 16'hFFFF, 16'hFFFF, w);  // darken from the top
		send_frame(2, 0, 0, 1, 8'd255, 16'h8000, 16'h8000, w);    // reversal halves steps
		send_frame(1, 100, 100, 0, 8'd0, 16'd5, 16'd5, w);        // disabled clears history
		send_frame(2, 120, 121, 1, 8'd123, 16'h1234, 16'h4321, w); // too small to correct
		send_frame(1, 255, 255, 1, 8'd0, 16'd0, 16'd0, w);        // nothing left to lower
		send_frame(1, 0, 0, 1, 8'd255, 16'hFFFF, 16'hFFFF, w);    // nothing left to raise
		send_frame(2, 200, 255, 1, 8'd10, 16'h9000, 16'h8000, w);
		send_frame(2, 0, 30, 1, 8'd200, 16'h8000, 16'h0010, w);
		drain();

		// Narrow ranges with a zero exposure step; includes the long output hold-off.
		load_regs(16'd100, 16'd1100, 16'd600, 16'd0, 16'd0, 16'd255, 16'd64, 16'd1);
		long_hold = 1;
		for (int i = 0; i < 12; i++)
			send_frame(1, 0, 255, 1, 8'($urandom_range(0, 255)), pick_setting(1),
				pick_setting(0), w);
		drain();
		random_frames(200);
		drain();

		// Inverted limits and extreme steps.
		load_regs(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		random_frames(200);
		drain();

		load_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd3, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
		random_frames(200);
		drain();

		load_regs(16'($urandom_range(0, 3000)), 16'($urandom_range(20000, 65535)),
			16'($urandom_range(3000, 20000)), 16'($urandom_range(1, 50)),
			16'($urandom_range(0, 100)), 16'($urandom_range(1000, 65535)),
			16'($urandom_range(100, 1000)), 16'($urandom_range(1, 9)));
		random_frames(200);
		drain();

		// Closing stretch without idling on either side.
		load_regs(16'd0, 16'hFFFF, 16'h8000, 16'd1, 16'd0, 16'hFFFF, 16'h8000, 16'd1);
		quiet = 1;
		random_frames(200);
		drain();

		if (errors == 0 && pending == 0)
			$display("auto_gain_exposure_control regression: pass");
		else
			$display("auto_gain_exposure_control regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/agec_pkg.sv
rtl/agec_div.sv
rtl/agec_fifo.sv
rtl/agec_front.sv
rtl/agec_back.sv
rtl/auto_gain_exposure_control.sv
rtl/agec_checker.sv
tb/sv/agec_scoreboard.sv
tb/sv/tb_top.sv
